### rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants and request/response types of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int PAGES      = 131072;
	localparam int WORD_BITS  = 64;
	localparam int PAGE_BYTES = 4096;
	localparam int MAP_WORDS  = (PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WADDR_W    = $clog2(MAP_WORDS);
	localparam int IDX_W      = $clog2(PAGES);
	localparam int RES_MIN    = (8 * 1024 * 1024) / PAGE_BYTES;
	localparam int RES_MAX    = (256 * 1024 * 1024) / PAGE_BYTES;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_FREE  = 2'd2;
	localparam logic [1:0] OP_ROOM  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_ROOM  = 3'd1;
	localparam logic [2:0] ST_ZERO_CNT = 3'd2;
	localparam logic [2:0] ST_MISALIGN = 3'd3;
	localparam logic [2:0] ST_RANGE    = 3'd4;
	localparam logic [2:0] ST_DOUBLE   = 3'd5;

	localparam logic CFG_RAM_BASE   = 1'b0;
	localparam logic CFG_PAGE_COUNT = 1'b1;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [47:0] address;
		logic [17:0] count;
	} req_t;

	typedef struct packed {
		logic [47:0] address_out;
		logic [2:0]  status;
		logic [17:0] free_pages;
		logic        room_ok;
	} rsp_t;

endpackage

### rtl/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bpa_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Page allocator over a free bitmap held in one synchronous RAM word array.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | bpa_pkg::req_t
//  rsp     | out       | rsp_valid / rsp_stall  | bpa_pkg::rsp_t
//  cfg     | in        | cfg_we                 | cfg_index, cfg_data
//
// One request is processed at a time; the bitmap RAM port sets the pace.
// A free checks its range, reads the word and writes it back. A single-page
// allocation reduces a cursor past the span by repeated subtraction, then
// reads and checks one word after another. A run scans the words it reads
// bit by bit, then reads and writes back each word it marks. After reset a
// clearing pass zeroes all 2048 bitmap words, during which requests stall.
// A finished response waits in the output register while the next request
// is taken; completion waits only while that register is full and stalled.
module bitmap_page_allocator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bpa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bpa_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [47:0]   cfg_data
);
	import bpa_pkg::*;

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_MOD      = 4'd2;
	localparam logic [3:0] S_ONE_RD   = 4'd3;
	localparam logic [3:0] S_ONE_CHK  = 4'd4;
	localparam logic [3:0] S_RUN_RD   = 4'd5;
	localparam logic [3:0] S_RUN_BIT  = 4'd6;
	localparam logic [3:0] S_MARK_RD  = 4'd7;
	localparam logic [3:0] S_MARK_WR  = 4'd8;
	localparam logic [3:0] S_FREE_CHK = 4'd9;
	localparam logic [3:0] S_FREE_RD  = 4'd10;
	localparam logic [3:0] S_FREE_WR  = 4'd11;
	localparam logic [3:0] S_FIN      = 4'd12;

	logic [3:0]           state_q;
	logic [WADDR_W:0]     clr_q;
	logic [47:0]          ram_base_q;
	logic [17:0]          page_count_q;
	logic [17:0]          total_q;
	logic [WADDR_W-1:0]   cursor_q;
	logic [WADDR_W-1:0]   w_q;
	logic [WADDR_W:0]     n_q;
	logic [17:0]          p_q;
	logic [17:0]          run_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     end_q;
	logic [47:0]          addr_q;
	logic [17:0]          cnt_q;
	logic [2:0]           status_q;
	logic                 room_q;
	logic                 alloc_q;
	logic                 out_valid_q;
	rsp_t                 out_q;

	logic                 mem_we;
	logic [WADDR_W-1:0]   mem_waddr;
	logic [63:0]          mem_wdata;
	logic                 mem_re;
	logic [WADDR_W-1:0]   mem_raddr;
	logic [63:0]          rdata;

	logic [17:0]          span;
	logic [WADDR_W:0]     words;
	logic [63:0]          lim_mask;
	logic [63:0]          one_v;
	logic [63:0]          one_iso;
	logic [5:0]           one_bit;
	logic [12:0]          res_raw;
	logic [16:0]          reserve;
	logic                 room_ans;
	logic [47:0]          diff;
	logic [IDX_W-1:0]     run_start;
	logic [5:0]           mark_lo;
	logic [5:0]           mark_hi;
	logic [63:0]          mark_mask;
	logic                 run_bit;
	logic                 accept;
	logic                 fin_go;

	bpa_ram #(.DEPTH(MAP_WORDS), .WIDTH(WORD_BITS)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	assign span  = (page_count_q > 18'(PAGES)) ? 18'(PAGES) : page_count_q;
	assign words = (WADDR_W + 1)'((19'(span) + 19'd63) >> 6);

	// The last word of the span only counts its bits below the span.
	always_comb begin
		lim_mask = '1;
		if (({1'b0, w_q} == words - 1'b1) && (span[5:0] != 6'd0)) begin
			lim_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << span[5:0]);
		end
	end

	assign one_v   = rdata & lim_mask;
	assign one_iso = one_v & (~one_v + 64'd1);

	always_comb begin
		one_bit = '0;
		for (int j = 0; j < 64; j++) begin
			if (one_iso[j]) begin
				one_bit = one_bit | 6'(j);
			end
		end
	end

	assign res_raw = span[17:5];
	always_comb begin
		if (res_raw < 13'(RES_MIN)) begin
			reserve = 17'(RES_MIN);
		end else begin
			reserve = 17'(res_raw);
		end
		if (reserve > 17'(RES_MAX)) begin
			reserve = 17'(RES_MAX);
		end
	end
	assign room_ans = (total_q > 18'(reserve)) && ((total_q - 18'(reserve)) >= req.count);

	assign diff      = addr_q - ram_base_q;
	assign run_bit   = rdata[p_q[5:0]];
	assign run_start = IDX_W'(p_q - cnt_q + 18'd1);

	assign mark_lo   = (w_q == idx_q[IDX_W-1:6]) ? idx_q[5:0] : 6'd0;
	assign mark_hi   = (w_q == end_q[IDX_W-1:6]) ? end_q[5:0] : 6'd63;
	assign mark_mask = (64'hFFFF_FFFF_FFFF_FFFF << mark_lo)
	                 & (64'hFFFF_FFFF_FFFF_FFFF >> (6'd63 - mark_hi));

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign fin_go    = (state_q == S_FIN) && (!out_valid_q || !rsp_stall);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = w_q;
		mem_wdata = rdata;
		mem_re    = 1'b0;
		mem_raddr = w_q;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q[WADDR_W-1:0];
				mem_wdata = '0;
			end
			S_ONE_RD, S_MARK_RD: begin
				mem_re = 1'b1;
			end
			S_ONE_CHK: begin
				mem_we    = (one_v != 64'd0);
				mem_wdata = rdata & ~one_iso;
			end
			S_RUN_RD: begin
				mem_re    = 1'b1;
				mem_raddr = p_q[IDX_W-1:6];
			end
			S_MARK_WR: begin
				mem_we    = 1'b1;
				mem_wdata = rdata & ~mark_mask;
			end
			S_FREE_RD: begin
				mem_re    = 1'b1;
				mem_raddr = idx_q[IDX_W-1:6];
			end
			S_FREE_WR: begin
				mem_we    = !rdata[idx_q[5:0]];
				mem_waddr = idx_q[IDX_W-1:6];
				mem_wdata = rdata | (64'd1 << idx_q[5:0]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_base_q   <= '0;
			page_count_q <= 18'd131072;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RAM_BASE:   ram_base_q   <= cfg_data;
				CFG_PAGE_COUNT: page_count_q <= cfg_data[17:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= req.address;
			cnt_q  <= req.count;
		end
		if (fin_go) begin
			out_q.address_out <= alloc_q ? (ram_base_q + {19'd0, idx_q, 12'd0}) : 48'd0;
			out_q.status      <= status_q;
			out_q.free_pages  <= total_q;
			out_q.room_ok     <= room_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			total_q     <= '0;
			cursor_q    <= '0;
			w_q         <= '0;
			n_q         <= '0;
			p_q         <= '0;
			run_q       <= '0;
			idx_q       <= '0;
			end_q       <= '0;
			status_q    <= ST_OK;
			room_q      <= 1'b0;
			alloc_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (WADDR_W + 1)'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						status_q <= ST_OK;
						room_q   <= 1'b0;
						alloc_q  <= 1'b0;
						w_q      <= cursor_q;
						p_q      <= '0;
						run_q    <= '0;
						state_q  <= S_FIN;
						case (req.opcode)
							OP_ALLOC: begin
								if (words == '0) begin
									status_q <= ST_NO_ROOM;
								end else begin
									state_q <= S_MOD;
								end
							end
							OP_RUN: begin
								if (req.count == 18'd0) begin
									status_q <= ST_ZERO_CNT;
								end else if (req.count == 18'd1) begin
									if (words == '0) begin
										status_q <= ST_NO_ROOM;
									end else begin
										state_q <= S_MOD;
									end
								end else if (req.count > span) begin
									status_q <= ST_NO_ROOM;
								end else begin
									state_q <= S_RUN_RD;
								end
							end
							OP_FREE: begin
								if (req.address[11:0] != 12'd0) begin
									status_q <= ST_MISALIGN;
								end else begin
									state_q <= S_FREE_CHK;
								end
							end
							OP_ROOM: begin
								room_q <= room_ans;
							end
							default: begin
							end
						endcase
					end
				end
				// The cursor may lie past a lowered span: reduce it by repeated subtraction.
				S_MOD: begin
					if ({1'b0, w_q} >= words) begin
						w_q <= WADDR_W'({1'b0, w_q} - words);
					end else begin
						n_q     <= '0;
						state_q <= S_ONE_RD;
					end
				end
				S_ONE_RD: begin
					state_q <= S_ONE_CHK;
				end
				S_ONE_CHK: begin
					if (one_v != 64'd0) begin
						idx_q    <= {w_q, one_bit};
						cursor_q <= w_q;
						alloc_q  <= 1'b1;
						if (total_q != 18'd0) begin
							total_q <= total_q - 18'd1;
						end
						state_q <= S_FIN;
					end else if (n_q + 1'b1 == words) begin
						status_q <= ST_NO_ROOM;
						state_q  <= S_FIN;
					end else begin
						n_q <= n_q + 1'b1;
						if ({1'b0, w_q} + 1'b1 == words) begin
							w_q <= '0;
						end else begin
							w_q <= w_q + 1'b1;
						end
						state_q <= S_ONE_RD;
					end
				end
				S_RUN_RD: begin
					state_q <= S_RUN_BIT;
				end
				// One bit a cycle between reads; a used bit restarts at the next page.
				S_RUN_BIT: begin
					if (run_bit && (run_q + 18'd1 == cnt_q)) begin
						idx_q   <= run_start;
						end_q   <= p_q[IDX_W-1:0];
						w_q     <= run_start[IDX_W-1:6];
						state_q <= S_MARK_RD;
					end else if (p_q + 18'd1 >= span) begin
						status_q <= ST_NO_ROOM;
						state_q  <= S_FIN;
					end else begin
						run_q <= run_bit ? run_q + 18'd1 : 18'd0;
						p_q   <= p_q + 18'd1;
						if (p_q[5:0] == 6'd63) begin
							state_q <= S_RUN_RD;
						end
					end
				end
				S_MARK_RD: begin
					state_q <= S_MARK_WR;
				end
				S_MARK_WR: begin
					if (w_q == end_q[IDX_W-1:6]) begin
						total_q <= (total_q >= cnt_q) ? total_q - cnt_q : 18'd0;
						alloc_q <= 1'b1;
						state_q <= S_FIN;
					end else begin
						w_q     <= w_q + 1'b1;
						state_q <= S_MARK_RD;
					end
				end
				S_FREE_CHK: begin
					if ((addr_q < ram_base_q) || (diff[47:12] >= 36'(span))) begin
						status_q <= ST_RANGE;
						state_q  <= S_FIN;
					end else begin
						idx_q   <= diff[12 +: IDX_W];
						state_q <= S_FREE_RD;
					end
				end
				S_FREE_RD: begin
					state_q <= S_FREE_WR;
				end
				S_FREE_WR: begin
					if (rdata[idx_q[5:0]]) begin
						status_q <= ST_DOUBLE;
					end else begin
						if (total_q != 18'h3FFFF) begin
							total_q <= total_q + 18'd1;
						end
						if (idx_q[IDX_W-1:6] < cursor_q) begin
							cursor_q <= idx_q[IDX_W-1:6];
						end
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

### rtl/bpa_checker.sv
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks of the bitmap page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bpa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input bpa_pkg::rsp_t rsp
);
	import bpa_pkg::*;

	// A waiting response holds its value until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// A failed operation never reports an address.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |-> rsp.address_out == 48'd0)
		else $error("address reported on failure");

	// A positive room answer comes only with a clean status and no address.
	a_room_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.room_ok |-> (rsp.status == ST_OK) && (rsp.address_out == 48'd0))
		else $error("room answer with status or address");

	// A request taken while idle makes the block busy on the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted without going busy");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap page allocator. Requests are driven with
// random gaps, responses are taken with random back-pressure, and each
// response is checked against a behavioural copy of the free bitmap, the
// free count and the next-fit cursor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
	import bpa_pkg::*;

	localparam longint unsigned CYCLE_LIMIT = 40_000_000;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	req_t          req = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b1;
	rsp_t          rsp;
	logic          cfg_we = 1'b0;
	logic          cfg_index = CFG_RAM_BASE;
	logic [47:0]   cfg_data = '0;

	bitmap_page_allocator i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Behavioural copy of the allocator state
	logic [63:0]  shadow_map [0:MAP_WORDS-1];
	int unsigned  shadow_free;
	int unsigned  shadow_cursor;
	logic [47:0]  shadow_base;
	logic [17:0]  shadow_pcount;

	rsp_t         pending_rsp [$];
	int unsigned  mismatches = 0;
	longint unsigned cycles = 0;
	bit           send_quiet = 1'b0;
	bit           recv_quiet = 1'b0;
	int unsigned  hold_ask = 0;

	initial begin
		forever begin
			#10 clk = ~clk;
			if (clk) begin
				cycles++;
				if (cycles > CYCLE_LIMIT) begin
					$display("[bitmap_page_allocator] ERROR");
					$finish;
				end
			end
		end
	end

	function automatic int unsigned span_now();
		return (shadow_pcount > PAGES) ? PAGES : 32'(shadow_pcount);
	endfunction

	function automatic void take_page(int unsigned i);
		shadow_map[i / 64][i % 64] = 1'b0;
		if (shadow_free > 0)
			shadow_free--;
	endfunction

	function automatic bit find_single(output int unsigned idx);
		int unsigned tot;
		int unsigned words;
		int unsigned w;
		int unsigned lim;
		logic [63:0] v;
		tot = span_now();
		words = (tot + 63) / 64;
		idx = 0;
		for (int unsigned n = 0; n < words; n++) begin
			w = (shadow_cursor + n) % words;
			v = shadow_map[w];
			lim = tot - w * 64;
			if (lim < 64)
				v &= (64'd1 << lim) - 64'd1;
			if (v != 0) begin
				for (int b = 0; b < 64; b++) begin
					if (v[b]) begin
						idx = w * 64 + b;
						break;
					end
				end
				take_page(idx);
				shadow_cursor = w;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic bit find_run(int unsigned cnt, output int unsigned idx);
		longint unsigned tot;
		longint unsigned start;
		int unsigned i;
		tot = span_now();
		idx = 0;
		start = 0;
		while (start + cnt <= tot) begin
			if (shadow_map[start / 64][start % 64]) begin
				for (i = 1; i < cnt; i++)
					if (!shadow_map[(start + i) / 64][(start + i) % 64])
						break;
				if (i < cnt) begin
					start += i;
				end else begin
					for (i = 0; i < cnt; i++)
						take_page(32'(start + i));
					idx = 32'(start);
					return 1'b1;
				end
			end
			start++;
		end
		return 1'b0;
	endfunction

	function automatic logic [2:0] give_back(logic [47:0] addr);
		logic [47:0] off;
		int unsigned i;
		if (addr[11:0] != 12'd0)
			return ST_MISALIGN;
		if (addr < shadow_base)
			return ST_RANGE;
		off = (addr - shadow_base) >> 12;
		if (off >= span_now())
			return ST_RANGE;
		i = 32'(off);
		if (shadow_map[i / 64][i % 64])
			return ST_DOUBLE;
		shadow_map[i / 64][i % 64] = 1'b1;
		if (shadow_free < 18'h3FFFF)
			shadow_free++;
		if (i / 64 < shadow_cursor)
			shadow_cursor = i / 64;
		return ST_OK;
	endfunction

	function automatic bit room_check(int unsigned pages);
		int unsigned reserve;
		reserve = span_now() / 32;
		if (reserve < RES_MIN)
			reserve = RES_MIN;
		if (reserve > RES_MAX)
			reserve = RES_MAX;
		return (shadow_free > reserve) && (shadow_free - reserve >= pages);
	endfunction

	function automatic rsp_t predict_response(req_t r);
		rsp_t o;
		int unsigned idx;
		bit ok;
		o = '0;
		o.status = ST_OK;
		case (r.opcode)
			OP_ALLOC: begin
				if (find_single(idx))
					o.address_out = shadow_base + 48'(idx) * 48'd4096;
				else
					o.status = ST_NO_ROOM;
			end
			OP_RUN: begin
				if (r.count == 0) begin
					o.status = ST_ZERO_CNT;
				end else begin
					ok = (r.count == 1) ? find_single(idx) : find_run(32'(r.count), idx);
					if (ok)
						o.address_out = shadow_base + 48'(idx) * 48'd4096;
					else
						o.status = ST_NO_ROOM;
				end
			end
			OP_FREE: o.status = give_back(r.address);
			default: o.room_ok = room_check(32'(r.count));
		endcase
		o.free_pages = shadow_free[17:0];
		return o;
	endfunction

	// Response side: back-pressure and checking
	int unsigned pause_left = 0;
	int unsigned hold_left = 0;
	int unsigned hold_ack = 0;

	always @(posedge clk) begin
		rsp_t want;
		if (rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response %p", rsp);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.address_out !== want.address_out || rsp.status !== want.status ||
				    rsp.free_pages !== want.free_pages || rsp.room_ok !== want.room_ok) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected addr %h st %0d free %0d room %0d, got addr %h st %0d free %0d room %0d",
							want.address_out, want.status, want.free_pages, want.room_ok,
							rsp.address_out, rsp.status, rsp.free_pages, rsp.room_ok);
				end
			end
			pause_left = recv_quiet ? 0 : $urandom_range(0, 15);
		end
		if (hold_ask != hold_ack) begin
			hold_ack = hold_ask;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (pause_left > 0) begin
			pause_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Sends one request; the caller is always at a rising edge.
	task automatic send_request(req_t r);
		int unsigned gap;
		gap = send_quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		pending_rsp.push_back(predict_response(r));
	endtask

	task automatic send_op(logic [1:0] op, logic [47:0] addr, logic [17:0] cnt);
		req_t r;
		r.opcode = op;
		r.address = addr;
		r.count = cnt;
		send_request(r);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [47:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_RAM_BASE)
			shadow_base = value;
		else
			shadow_pcount = value[17:0];
	endtask

	function automatic logic [47:0] page_at(int unsigned idx);
		return shadow_base + 48'(idx) * 48'd4096;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int unsigned k;
		int unsigned sp;
		sp = span_now();
		k = $urandom_range(0, 99);
		r.address = 48'({$urandom, $urandom});
		r.count = 18'($urandom);
		if (k < 40) begin
			r.opcode = OP_FREE;
			r.address = page_at($urandom_range(0, sp + sp / 8));
		end else if (k < 48) begin
			r.opcode = OP_FREE;
			case ($urandom_range(0, 2))
				0: r.address = page_at($urandom_range(0, sp)) | 48'($urandom_range(1, 4095));
				1: r.address = shadow_base - 48'd4096 * 48'($urandom_range(1, 8));
				default: ;
			endcase
		end else if (k < 72) begin
			r.opcode = OP_ALLOC;
		end else if (k < 88) begin
			r.opcode = OP_RUN;
			if ($urandom_range(0, 9) != 0)
				r.count = 18'($urandom_range(0, 6));
		end else begin
			r.opcode = OP_ROOM;
			if ($urandom_range(0, 1) != 0)
				r.count = 18'($urandom_range(0, 64));
		end
		return r;
	endfunction

	// State straight after reset: nothing free, full span
	task automatic test_reset_state();
		send_op(OP_ALLOC, '0, '0);
		send_op(OP_RUN, '0, 18'd0);
		send_op(OP_RUN, '1, 18'd2);
		send_op(OP_ROOM, '0, 18'd0);
		send_op(OP_FREE, 48'd5 * 48'd4096, 18'h3FFFF);
		send_op(OP_RUN, '0, 18'h3FFFF);
	endtask

	// Address checks, double free, wrap of the address sum and oversized runs
	task automatic test_free_checks();
		write_reg(CFG_RAM_BASE, 48'hFFFF_FFFF_F000);
		write_reg(CFG_PAGE_COUNT, 48'd64);
		send_op(OP_FREE, page_at(0), '0);
		send_op(OP_FREE, page_at(0), '0);
		send_op(OP_FREE, page_at(0) | 48'h001, '0);
		send_op(OP_FREE, page_at(0) - 48'd4096, '0);
		send_op(OP_FREE, page_at(64), '0);
		send_op(OP_FREE, page_at(3), '0);
		send_op(OP_ALLOC, '0, '0);
		send_op(OP_RUN, '0, 18'd1);
		send_op(OP_RUN, '0, 18'd65);
		send_op(OP_ROOM, '0, 18'h3FFFF);
	endtask

	// Empty span, oversized page_count, bits past the span, cursor past the span
	task automatic test_span_edges();
		write_reg(CFG_RAM_BASE, 48'd0);
		write_reg(CFG_PAGE_COUNT, 48'd0);
		send_op(OP_ALLOC, '0, '0);
		send_op(OP_FREE, 48'd0, '0);
		write_reg(CFG_PAGE_COUNT, 48'h3FFFF);
		send_op(OP_FREE, page_at(131071), '0);
		send_op(OP_FREE, page_at(200), '0);
		send_op(OP_ALLOC, '0, '0);
		send_op(OP_FREE, page_at(130000), '0);
		send_op(OP_ALLOC, '0, '0);
		write_reg(CFG_PAGE_COUNT, 48'd128);
		send_op(OP_FREE, page_at(70), '0);
		send_op(OP_ALLOC, '0, '0);
		send_op(OP_FREE, page_at(100), '0);
		write_reg(CFG_PAGE_COUNT, 48'd64);
		send_op(OP_ALLOC, '0, '0);
		send_op(OP_ROOM, '0, 18'd1);
	endtask

	task automatic test_random();
		int unsigned sp;
		for (int phase = 0; phase < 11; phase++) begin
			case (phase % 4)
				0: sp = 64;
				1: sp = $urandom_range(65, 512);
				2: sp = 100;
				default: sp = $urandom_range(64, 256);
			endcase
			write_reg(CFG_PAGE_COUNT, 48'(sp));
			case (phase % 3)
				0: write_reg(CFG_RAM_BASE, 48'({$urandom_range(0, 15), $urandom} << 12));
				1: write_reg(CFG_RAM_BASE, 48'd0);
				default: write_reg(CFG_RAM_BASE, 48'hFFFF_FFFF_F000 - 48'd4096 * 48'($urandom_range(0, 300)));
			endcase
			send_quiet = (phase % 4 == 3);
			recv_quiet = (phase % 5 == 4);
			for (int n = 0; n < 100; n++)
				send_request(random_request());
		end
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
	endtask

	// Receiver holds off while requests keep coming, then the sender waits for all
	task automatic test_pressure();
		send_quiet = 1'b1;
		hold_ask <= hold_ask + 1;
		for (int n = 0; n < 20; n++)
			send_request(random_request());
		send_quiet = 1'b0;
		drain();
		for (int n = 0; n < 20; n++)
			send_request(random_request());
	endtask

	initial begin
		for (int w = 0; w < MAP_WORDS; w++)
			shadow_map[w] = '0;
		shadow_free = 0;
		shadow_cursor = 0;
		shadow_base = '0;
		shadow_pcount = 18'd131072;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_free_checks();
		test_span_edges();
		test_random();
		test_pressure();
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("[bitmap_page_allocator] OK");
		else
			$display("[bitmap_page_allocator] ERROR");
		$finish;
	end

endmodule

### files.f
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bitmap_page_allocator.sv
rtl/bpa_checker.sv
bench/tb_top.sv
